FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the token run splitter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define TTS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the default clk_i / rst_ni pair of the enclosing scope.
`define TTS_ASSERT(lbl, prop, msg) \
  `TTS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the text token run splitter.
// ----------------------------------------------------------------------------
package tts_pkg;

  typedef enum logic [1:0] {
    ClsSpace = 2'd0,
    ClsAlpha = 2'd1,
    ClsDigit = 2'd2,
    ClsOther = 2'd3
  } run_class_e;

  // Longest text the offset counter is sized for; offsets saturate below it.
  localparam int unsigned MaxTextBytes = 65536;
  localparam logic [15:0] OffsetCap =
    ((MaxTextBytes - 1) < 65535) ? 16'(MaxTextBytes - 1) : 16'hFFFF;

  // Result queue: two pushes per cycle at most, one pop.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data;    // byte after lower-casing
    run_class_e cls;
    logic       lead;    // other-class lead byte, opens a new token
    logic [1:0] extra;   // continuation bytes following a lead
  } byte_info_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] offset;
    run_class_e  cls;
    logic        first;
    logic        last;
    logic        done;
  } result_t;

  typedef struct packed {
    logic [1:0] count;   // 0, 1 or 2 results this cycle
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: hdl/tts_if.sv
// ----------------------------------------------------------------------------
// tts_if
// Valid/ready channels for text bytes in and classified bytes out.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] byte_offset;
  logic [1:0]  run_class;
  logic        run_first;
  logic        run_last;
  logic        text_done;

  modport source (output valid, output out_byte, output byte_offset, output run_class,
                  output run_first, output run_last, output text_done, input ready);
  modport sink   (input valid, input out_byte, input byte_offset, input run_class,
                  input run_first, input run_last, input text_done, output ready);
endinterface

FILE: hdl/text_token_run_splitter_top.sv
// ----------------------------------------------------------------------------
// text_token_run_splitter_top
// Character-class run tokenizer: one text byte in, classified bytes out.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the result queue has room and reports
// each byte one item late, once the next byte shows whether the run goes on:
// class (space, letter, digit, other), offset in the text (saturating at the
// offset cap), run-first and run-last marks, and letters lower-cased. A byte
// flagged end_of_text flushes both the held byte, if any, and itself, so it
// yields up to two result items; every other byte yields at most one. Input
// side: one item per cycle while the queue has room; a result passes the
// input register, then the result queue. Output side: one result item per
// cycle while out_o.ready is high. A text of L bytes gives exactly L result
// items (above one byte, the first gives none and the last gives two); the
// four-entry result queue sets how far input runs ahead while output stalls.
// ----------------------------------------------------------------------------
module text_token_run_splitter_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  tts_in_if.sink   in_i,
  tts_out_if.source out_o
);
  import tts_pkg::*;

  push_t   push;        // results produced this cycle
  logic    can_push;    // queue has room for a pair
  result_t out_res;
  logic    out_valid;

  // Input register plus run state; classifies and decides run boundaries.
  tts_run_track u_run_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.text_byte),
    .in_eot_i   (in_i.end_of_text),
    .in_ready_o (in_i.ready),
    .can_push_i (can_push),
    .push_o     (push)
  );

  // Result queue decouples the two sides and spreads the end-of-text pair.
  tts_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .can_push_o  (can_push),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  assign out_o.valid       = out_valid;
  assign out_o.out_byte    = out_res.data;
  assign out_o.byte_offset = out_res.offset;
  assign out_o.run_class   = out_res.cls;
  assign out_o.run_first   = out_res.first;
  assign out_o.run_last    = out_res.last;
  assign out_o.text_done   = out_res.done;

endmodule

FILE: hdl/tts_classify.sv
// ----------------------------------------------------------------------------
// tts_classify
// Byte classifier: character class, UTF-8 lead length, lower-casing.
// ----------------------------------------------------------------------------
module tts_classify (
  input  logic [7:0]          data_i,
  input  logic                cont_active_i,  // byte is a continuation of a token
  output tts_pkg::byte_info_t info_o
);
  import tts_pkg::*;

  function automatic run_class_e classify(input logic [7:0] b);
    run_class_e c;
    c = ClsOther;
    if (b[7]) begin
      c = ClsOther;
    end else if (b inside {[8'h30:8'h39]}) begin
      c = ClsDigit;
    end else if (b <= 8'h20 || b == 8'h7F) begin
      c = ClsSpace;
    end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      c = ClsAlpha;
    end
    return c;
  endfunction

  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= 8'hF0) begin
      n = 2'd3;
    end else if (b >= 8'hE0) begin
      n = 2'd2;
    end else if (b >= 8'hC0) begin
      n = 2'd1;
    end
    return n;
  endfunction

  run_class_e cls;

  assign cls = classify(data_i);

  always_comb begin
    info_o.data  = data_i;
    info_o.cls   = cls;
    info_o.lead  = 1'b0;
    info_o.extra = 2'd0;
    if (cont_active_i) begin
      info_o.cls = ClsOther;
    end else if (cls == ClsOther) begin
      info_o.lead  = 1'b1;
      info_o.extra = lead_extra(data_i);
    end else if (cls == ClsAlpha) begin
      info_o.data = data_i | 8'h20;   // uppercase and lowercase differ in bit 5
    end
  end

endmodule

FILE: hdl/tts_run_track.sv
// ----------------------------------------------------------------------------
// tts_run_track
// Input register, run state and result generation, one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module tts_run_track (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eot_i,
  output logic            in_ready_o,
  input  logic            can_push_i,
  output tts_pkg::push_t  push_o
);
  import tts_pkg::*;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eot_q;

  // run state
  logic        held_valid_q, held_valid_d;
  logic [7:0]  held_byte_q, held_byte_d;
  run_class_e  held_cls_q, held_cls_d;
  logic        held_first_q, held_first_d;
  logic [15:0] next_off_q, next_off_d;
  logic [1:0]  cont_q, cont_d;

  byte_info_t  info;
  logic        cont_active;
  logic        fire;
  logic        first;
  logic [16:0] off_inc;
  logic [15:0] off_new;
  result_t     res_held;
  result_t     res_new;

  assign cont_active = (cont_q != 2'd0);
  assign fire        = in_valid_q && can_push_i;
  assign in_ready_o  = !in_valid_q || can_push_i;

  tts_classify u_classify (
    .data_i        (in_byte_q),
    .cont_active_i (cont_active),
    .info_o        (info)
  );

  always_comb begin
    if (cont_active) begin
      first = 1'b0;
    end else if (info.lead) begin
      first = 1'b1;
    end else begin
      first = !(held_valid_q && held_cls_q == info.cls);
    end
  end

  // offset of the incoming byte: one past the held byte, saturating
  assign off_inc = {1'b0, next_off_q} + 17'd1;
  always_comb begin
    if (!held_valid_q) begin
      off_new = next_off_q;
    end else if (off_inc > {1'b0, OffsetCap}) begin
      off_new = OffsetCap;
    end else begin
      off_new = off_inc[15:0];
    end
  end

  always_comb begin
    res_held.data   = held_byte_q;
    res_held.offset = next_off_q;
    res_held.cls    = held_cls_q;
    res_held.first  = held_first_q;
    res_held.last   = first;
    res_held.done   = 1'b0;

    res_new.data    = info.data;
    res_new.offset  = off_new;
    res_new.cls     = info.cls;
    res_new.first   = first;
    res_new.last    = 1'b1;
    res_new.done    = 1'b1;

    push_o.r0 = held_valid_q ? res_held : res_new;
    push_o.r1 = res_new;
    if (fire) begin
      push_o.count = {1'b0, held_valid_q} + {1'b0, in_eot_q};
    end else begin
      push_o.count = 2'd0;
    end
  end

  always_comb begin
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    held_cls_d   = held_cls_q;
    held_first_d = held_first_q;
    next_off_d   = next_off_q;
    cont_d       = cont_q;
    if (fire) begin
      if (in_eot_q) begin
        // text ends: back to reset, a cut-off token drops its count
        held_valid_d = 1'b0;
        held_cls_d   = ClsSpace;
        held_first_d = 1'b0;
        next_off_d   = '0;
        cont_d       = 2'd0;
      end else begin
        held_valid_d = 1'b1;
        held_byte_d  = info.data;
        held_cls_d   = info.cls;
        held_first_d = first;
        next_off_d   = off_new;
        if (cont_active) begin
          cont_d = cont_q - 2'd1;
        end else begin
          cont_d = info.extra;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_cls_q   <= ClsSpace;
      held_first_q <= 1'b0;
      next_off_q   <= '0;
      cont_q       <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      held_valid_q <= held_valid_d;
      held_cls_q   <= held_cls_d;
      held_first_q <= held_first_d;
      next_off_q   <= next_off_d;
      cont_q       <= cont_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eot_q  <= in_eot_i;
    end
    held_byte_q <= held_byte_d;
  end

endmodule

FILE: hdl/tts_out_queue.sv
// ----------------------------------------------------------------------------
// tts_out_queue
// Small result queue: up to two writes per cycle, one read from the entry registers.
// ----------------------------------------------------------------------------
module tts_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tts_pkg::push_t   push_i,
  output logic             can_push_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tts_pkg::result_t out_res_o
);
  import tts_pkg::*;

  result_t            entry_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q;
  logic [QPtrW-1:0]   rd_ptr_q;
  logic [QCntW-1:0]   count_q;
  logic [QPtrW-1:0]   wr_ptr_nx;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full pair of results, judged before this cycle's pop
  assign can_push_o  = (count_q <= QCntW'(QueueDepth - 2));
  assign wr_ptr_nx   = QPtrW'(wr_ptr_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= QPtrW'(wr_ptr_q + QPtrW'(push_i.count));
      if (pop) begin
        rd_ptr_q <= QPtrW'(rd_ptr_q + 1'b1);
      end
      count_q <= QCntW'(count_q + QCntW'(push_i.count) - QCntW'(pop));
    end
  end

endmodule

FILE: hdl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the token run splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic [15:0] byte_offset_i,
  input logic [1:0]  run_class_i,
  input logic        run_first_i,
  input logic        run_last_i,
  input logic        text_done_i
);
  import tts_pkg::*;

  logic [28:0] payload;

  assign payload = {out_byte_i, byte_offset_i, run_class_i, run_first_i, run_last_i,
                    text_done_i};

  `TTS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload), "output item changed while stalled")
  `TTS_ASSERT(a_done_last, out_valid_i && text_done_i |-> run_last_i, "end of text without run end")
  `TTS_ASSERT(a_alpha_lower, out_valid_i && run_class_i == ClsAlpha |-> out_byte_i >= 8'h61 && out_byte_i <= 8'h7A, "letter not lower case")
  `TTS_ASSERT(a_digit_range, out_valid_i && run_class_i == ClsDigit |-> out_byte_i >= 8'h30 && out_byte_i <= 8'h39, "digit class on non-digit")

endmodule

bind text_token_run_splitter_top tts_checker u_tts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .byte_offset_i (out_o.byte_offset),
  .run_class_i   (out_o.run_class),
  .run_first_i   (out_o.run_first),
  .run_last_i    (out_o.run_last),
  .text_done_i   (out_o.text_done)
);
